// File: hw/rtl/port_bitmap_allocator_macros.svh
// ---------------------------------------------------------------------------
// port_bitmap_allocator_macros.svh
// Assertion macros for the port bitmap allocator. Both expect clk and rst_n
// in scope and stay silent while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef PORT_BITMAP_ALLOCATOR_MACROS_SVH
`define PORT_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define PBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PBA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PBA_ASSERT(lbl, prop, msg)

`define PBA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: hw/rtl/pba_pkg.sv
// ---------------------------------------------------------------------------
// pba_pkg
// Types and constants shared by the port bitmap allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  localparam int PORT_W     = 16;
  localparam int PORT_COUNT = 65536;
  localparam int WORD_W     = 32;
  localparam int OFF_W      = 5;
  localparam int MAP_WORDS  = (PORT_COUNT + WORD_W - 1) / WORD_W;
  localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W      = $clog2(MAP_WORDS + 1);
  localparam int TAIL_BITS  = PORT_COUNT % WORD_W;

  // bits of the last map word that lie beyond the port range read as used
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL_BITS == 0) ? '0 : ~((WORD_W'(1) << TAIL_BITS) - WORD_W'(1));
  localparam logic [MAP_AW-1:0] LAST_WORD  = MAP_AW'(MAP_WORDS - 1);
  localparam logic [PORT_W:0]   PORT_LIMIT = (PORT_W + 1)'(PORT_COUNT);

  typedef struct packed {
    logic [PORT_W-1:0] requested_port;
    logic              shared;
  } pba_in_t;

  typedef struct packed {
    logic [PORT_W-1:0] granted_port;
    logic              already_taken;
  } pba_out_t;

  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } pba_mem_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/pba_map.sv
// ---------------------------------------------------------------------------
// pba_map
// In-use bitmap store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pba_map
  import pba_pkg::*;
(
  input  logic              clk,
  input  pba_mem_req_t      mem_req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/pba_find.sv
// ---------------------------------------------------------------------------
// pba_find
// Masks one map word for the current search visit and returns the lowest
// clear bit.
// ---------------------------------------------------------------------------
`default_nettype none

module pba_find
  import pba_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic              first_visit,
  input  logic              last_visit,
  input  logic              tail_word,
  input  logic [OFF_W-1:0]  offset,
  output logic              found,
  output logic [OFF_W-1:0]  idx
);

  logic [WORD_W-1:0] below;
  logic [WORD_W-1:0] masked;

  // first visit skips bits below the start, the wrapped visit the rest
  always_comb begin
    below  = (WORD_W'(1) << offset) - WORD_W'(1);
    masked = word;
    if (first_visit) begin
      masked = masked | below;
    end
    if (last_visit) begin
      masked = masked | ~below;
    end
    if (tail_word) begin
      masked = masked | TAIL_MASK;
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        found = 1'b1;
        idx   = OFF_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/port_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// port_bitmap_allocator
// Next-fit port allocator over an in-use bitmap held in a synchronous store.
//
//   channel   ports                     handshake
//   input     in_data                   start & !busy
//   result    out_data                  out_valid, one cycle, no stall
//
// After reset all 2048 map words are cleared, busy high throughout.
// A specific port is handled in order: read, check/mark, busy low again;
// the result word follows in the cycle after the check.
// An any-port request walks one map word a cycle from the hint until a
// clear bit is found or the whole map has been visited.
// Results are strobed once; the receiver cannot stall them.
// ---------------------------------------------------------------------------
`default_nettype none

`include "port_bitmap_allocator_macros.svh"

module port_bitmap_allocator
  import pba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pba_in_t  in_data,
  output logic     out_valid,
  output pba_out_t out_data
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CHECK = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MAP_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [PORT_W-1:0] hint_r, hint_nxt;
  logic [PORT_W-1:0] req_r, req_nxt;
  logic              shared_r, shared_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [MAP_AW-1:0] scan_addr_r, scan_addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  pba_out_t          out_data_r, out_data_nxt;

  pba_mem_req_t      mem_req;
  logic [WORD_W-1:0] rd_data;
  logic [PORT_W-1:0] start_port;
  logic [MAP_AW-1:0] next_addr;
  logic              find_found;
  logic [OFF_W-1:0]  find_idx;
  logic              last_visit;

  pba_map u_map (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  assign last_visit = (cnt_r == CNT_W'(MAP_WORDS));

  pba_find u_find (
    .word        (rd_data),
    .first_visit (cnt_r == '0),
    .last_visit  (last_visit),
    .tail_word   (scan_addr_r == LAST_WORD),
    .offset      (off_r),
    .found       (find_found),
    .idx         (find_idx)
  );

  assign start_port = ({1'b0, hint_r} >= PORT_LIMIT) ? '0 : hint_r;
  assign next_addr  = (scan_addr_r == LAST_WORD) ? '0 : scan_addr_r + MAP_AW'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    hint_nxt      = hint_r;
    req_nxt       = req_r;
    shared_nxt    = shared_r;
    off_nxt       = off_r;
    scan_addr_nxt = scan_addr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_req       = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_r;
        mem_req.wr_data = (clr_addr_r == '0) ? WORD_W'(1) : '0;
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + MAP_AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_data.requested_port;
          shared_nxt = in_data.shared;
          if (in_data.requested_port == '0) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = start_port[OFF_W +: MAP_AW];
            scan_addr_nxt   = start_port[OFF_W +: MAP_AW];
            off_nxt         = start_port[OFF_W-1:0];
            cnt_nxt         = '0;
            state_nxt       = S_SCAN;
          end else if ({1'b0, in_data.requested_port} < PORT_LIMIT) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = in_data.requested_port[OFF_W +: MAP_AW];
            scan_addr_nxt   = in_data.requested_port[OFF_W +: MAP_AW];
            off_nxt         = in_data.requested_port[OFF_W-1:0];
            state_nxt       = S_CHECK;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end
        end
      end
      S_CHECK: begin
        out_valid_nxt = 1'b1;
        if (rd_data[off_r]) begin
          out_data_nxt.granted_port  = shared_r ? req_r : '0;
          out_data_nxt.already_taken = 1'b1;
        end else begin
          mem_req.wr_en              = 1'b1;
          mem_req.wr_addr            = scan_addr_r;
          mem_req.wr_data            = rd_data | (WORD_W'(1) << off_r);
          out_data_nxt.granted_port  = req_r;
          out_data_nxt.already_taken = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (find_found) begin
          mem_req.wr_en              = 1'b1;
          mem_req.wr_addr            = scan_addr_r;
          mem_req.wr_data            = rd_data | (WORD_W'(1) << find_idx);
          out_valid_nxt              = 1'b1;
          out_data_nxt.granted_port  = PORT_W'({scan_addr_r, find_idx});
          out_data_nxt.already_taken = 1'b0;
          hint_nxt                   = PORT_W'({scan_addr_r, find_idx});
          state_nxt                  = S_IDLE;
        end else if (last_visit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          hint_nxt      = '0;
          state_nxt     = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = next_addr;
          scan_addr_nxt   = next_addr;
          cnt_nxt         = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      hint_r      <= PORT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    shared_r    <= shared_nxt;
    off_r       <= off_nxt;
    scan_addr_r <= scan_addr_nxt;
    cnt_r       <= cnt_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PBA_ASSERT(a_out_source, out_valid |-> ($past(state_r) == S_CHECK || $past(state_r) == S_SCAN || ($past(state_r) == S_IDLE && $past(start))), "result word without a request")
  `PBA_ASSERT(a_scan_bound, state_r == S_SCAN |-> cnt_r <= CNT_W'(MAP_WORDS), "search ran past the map")
  `PBA_ASSERT_NEVER(a_idle_write, state_r == S_IDLE && mem_req.wr_en, "map written while idle")
  `PBA_ASSERT_NEVER(a_port0_grant, out_valid && !out_data.already_taken && out_data.granted_port == '0 && $past(state_r) == S_CHECK, "reserved port granted")

endmodule

`default_nettype wire
